### sv/jbt_pkg.sv
// Shared types, codes and letter tables for the byte-serial JSON tokenizer.
// Depends on nothing; the tokenizer and checker refer to it by scoped names, the testbench imports it.

package jbt_pkg;

	// Register reset
	localparam logic [15:0] MAX_LEN_RESET = 16'd16383;

	// Lexer modes
	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_ERROR   = 4'd1,
		M_STR     = 4'd2,
		M_STR_ESC = 4'd3,
		M_N_MINUS = 4'd4,
		M_N_ZERO  = 4'd5,
		M_N_INT   = 4'd6,
		M_N_DOT   = 4'd7,
		M_N_FRAC  = 4'd8,
		M_N_E     = 4'd9,
		M_N_ESIGN = 4'd10,
		M_N_EXP   = 4'd11,
		M_LIT     = 4'd12
	} lex_mode_t;

	// Result event codes
	typedef enum logic [1:0] {
		EV_CONTENT = 2'd0,
		EV_TOKEN   = 2'd1,
		EV_ERROR   = 2'd2,
		EV_END     = 2'd3
	} event_t;

	// Token kinds
	localparam logic [3:0] K_NULL   = 4'd0;
	localparam logic [3:0] K_NUMBER = 4'd1;
	localparam logic [3:0] K_STRING = 4'd2;
	localparam logic [3:0] K_TRUE   = 4'd3;
	localparam logic [3:0] K_FALSE  = 4'd4;
	localparam logic [3:0] K_LBRACE = 4'd5;
	localparam logic [3:0] K_RBRACE = 4'd6;
	localparam logic [3:0] K_LBRACK = 4'd7;
	localparam logic [3:0] K_RBRACK = 4'd8;
	localparam logic [3:0] K_COMMA  = 4'd9;
	localparam logic [3:0] K_COLON  = 4'd10;

	// Literal selector
	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	// One result as queued for output
	typedef struct packed {
		event_t     ev;
		logic [3:0] kind;
		logic [7:0] data;
		logic       last;
	} res_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	// Length of each literal
	function automatic logic [2:0] lit_len(input logic [1:0] w);
		logic [2:0] n;
		unique case (w)
			LIT_TRUE:  n = 3'd4;
			LIT_FALSE: n = 3'd5;
			LIT_NULL:  n = 3'd4;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

	// Token kind of each literal
	function automatic logic [3:0] lit_kind(input logic [1:0] w);
		logic [3:0] k;
		unique case (w)
			LIT_TRUE:  k = K_TRUE;
			LIT_FALSE: k = K_FALSE;
			default:   k = K_NULL;
		endcase
		return k;
	endfunction

	// Expected letter at a given position of a literal
	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
		logic [7:0] c;
		c = 8'h00;
		unique case (w)
			LIT_TRUE: begin
				case (p)
					3'd0: c = "t";
					3'd1: c = "r";
					3'd2: c = "u";
					3'd3: c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				case (p)
					3'd0: c = "f";
					3'd1: c = "a";
					3'd2: c = "l";
					3'd3: c = "s";
					3'd4: c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (p)
					3'd0: c = "n";
					3'd1: c = "u";
					3'd2: c = "l";
					3'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### sv/jbt_if.sv
// Valid/ready channel interfaces for the tokenizer: text bytes in, results out.
// Standalone; no package needed.

interface jbt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       restart;

	modport source (output valid, output in_byte, output restart, input ready);
	modport sink   (input valid, input in_byte, input restart, output ready);
	modport mon    (input valid, input in_byte, input restart, input ready);
endinterface

interface jbt_token_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [3:0] token_kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output event_res, output token_kind, output out_byte,
		output last, input ready);
	modport sink   (input valid, input event_res, input token_kind, input out_byte,
		input last, output ready);
	modport mon    (input valid, input event_res, input token_kind, input out_byte,
		input last, input ready);
endinterface

### sv/json_byte_tokenizer.sv
// Byte-serial JSON lexer: one text byte per transaction in, token results out.
// Depends on jbt_pkg and the channel interfaces in jbt_if.sv.

// The tokenizer takes one text byte per cycle while ready. Each accepted byte is decoded
// against the lexer state in the same cycle and its zero, one or two results
// are written into a four-entry result queue, which holds them from the cycle
// after the byte is accepted. A byte that closes a number and also
// starts a new token gives two results, which leave the queue one after the
// other. The text channel is ready whenever at least two queue entries are
// free. With the result side always taking, the block sustains one byte per
// cycle as long as bytes average no more than one result each; text such as
// "1,1,1," gives three results per two bytes, so the single result per cycle
// sets the pace there and input is held off as the queue fills, as it is when
// results back up. max_len_q is to be written through wr_en/wr_data only while
// the block is idle; the block itself does not enforce this.

module json_byte_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	jbt_text_if.sink    text,
	jbt_token_if.source tokens,
	input  logic        wr_en,
	input  logic [15:0] wr_data
);

	typedef struct packed {
		jbt_pkg::lex_mode_t mode;
		logic [1:0]         which;
		logic [2:0]         pos;
		logic [15:0]        cnt;
		logic               v;
		jbt_pkg::res_t      res;
	} start_t;

	// New token from idle or after a number; count 0 for a string, 1 for a number
	function automatic start_t start_tok(input logic [7:0] b, input logic [15:0] maxl);
		start_t st;
		st = '0;
		st.mode = jbt_pkg::M_IDLE;
		case (b) inside
			8'h00: begin
				st.v = 1'b1;
				st.res.ev = jbt_pkg::EV_END;
			end
			" ", 8'h09, 8'h0a, 8'h0d: st.v = 1'b0;
			"{": begin st.v = 1'b1; st.res.ev = jbt_pkg::EV_TOKEN; st.res.kind = jbt_pkg::K_LBRACE; end
			"}": begin st.v = 1'b1; st.res.ev = jbt_pkg::EV_TOKEN; st.res.kind = jbt_pkg::K_RBRACE; end
			"[": begin st.v = 1'b1; st.res.ev = jbt_pkg::EV_TOKEN; st.res.kind = jbt_pkg::K_LBRACK; end
			"]": begin st.v = 1'b1; st.res.ev = jbt_pkg::EV_TOKEN; st.res.kind = jbt_pkg::K_RBRACK; end
			",": begin st.v = 1'b1; st.res.ev = jbt_pkg::EV_TOKEN; st.res.kind = jbt_pkg::K_COMMA; end
			":": begin st.v = 1'b1; st.res.ev = jbt_pkg::EV_TOKEN; st.res.kind = jbt_pkg::K_COLON; end
			"\"": st.mode = jbt_pkg::M_STR;
			"t": begin st.mode = jbt_pkg::M_LIT; st.which = jbt_pkg::LIT_TRUE; st.pos = 3'd1; end
			"f": begin st.mode = jbt_pkg::M_LIT; st.which = jbt_pkg::LIT_FALSE; st.pos = 3'd1; end
			"n": begin st.mode = jbt_pkg::M_LIT; st.which = jbt_pkg::LIT_NULL; st.pos = 3'd1; end
			"-", ["0":"9"]: begin
				st.v = 1'b1;
				if (maxl == 16'd0) begin
					st.mode   = jbt_pkg::M_ERROR;
					st.res.ev = jbt_pkg::EV_ERROR;
				end else begin
					st.cnt      = 16'd1;
					st.res.ev   = jbt_pkg::EV_CONTENT;
					st.res.kind = jbt_pkg::K_NUMBER;
					st.res.data = b;
					if (b == "-")
						st.mode = jbt_pkg::M_N_MINUS;
					else if (b == "0")
						st.mode = jbt_pkg::M_N_ZERO;
					else
						st.mode = jbt_pkg::M_N_INT;
				end
			end
			default: begin
				st.v      = 1'b1;
				st.mode   = jbt_pkg::M_ERROR;
				st.res.ev = jbt_pkg::EV_ERROR;
			end
		endcase
		return st;
	endfunction

	// Lexer state and register
	jbt_pkg::lex_mode_t mode_q, mode_e, mode_d;
	logic [1:0]         which_q, which_e, which_d;
	logic [2:0]         pos_q, pos_e, pos_d;
	logic [15:0]        cnt_q, cnt_e, cnt_d;
	logic [15:0]        max_len_q;

	// Result queue
	jbt_pkg::res_t fifo_q [4];
	logic [1:0]    wr_ptr_q, rd_ptr_q;
	logic [2:0]    fill_q;

	logic          accept, pop;
	logic          r0_v, r1_v;
	jbt_pkg::res_t r0, r1;
	start_t        st;
	logic [7:0]    b;
	logic          d, e, num_end, num_bad, num_go, lit_ok;
	jbt_pkg::lex_mode_t num_nx;

	assign b      = text.in_byte;
	assign accept = text.valid && text.ready;
	assign pop    = tokens.valid && tokens.ready;

	assign text.ready = (fill_q <= 3'd2);

	// State seen by this byte after an optional restart
	always_comb begin
		if (text.restart) begin
			mode_e  = jbt_pkg::M_IDLE;
			which_e = 2'd0;
			pos_e   = 3'd0;
			cnt_e   = 16'd0;
		end else begin
			mode_e  = mode_q;
			which_e = which_q;
			pos_e   = pos_q;
			cnt_e   = cnt_q;
		end
	end

	// Number grammar step
	always_comb begin
		d       = jbt_pkg::is_digit(b);
		e       = (b == "e") || (b == "E");
		num_nx  = mode_e;
		num_end = 1'b0;
		num_bad = 1'b0;
		case (mode_e)
			jbt_pkg::M_N_MINUS: begin
				if (b == "0") num_nx = jbt_pkg::M_N_ZERO;
				else if (d)   num_nx = jbt_pkg::M_N_INT;
				else          num_bad = 1'b1;
			end
			jbt_pkg::M_N_ZERO: begin
				if (b == ".")  num_nx = jbt_pkg::M_N_DOT;
				else if (e)    num_nx = jbt_pkg::M_N_E;
				else if (d)    num_bad = 1'b1;
				else           num_end = 1'b1;
			end
			jbt_pkg::M_N_INT: begin
				if (d)             num_nx = jbt_pkg::M_N_INT;
				else if (b == ".") num_nx = jbt_pkg::M_N_DOT;
				else if (e)        num_nx = jbt_pkg::M_N_E;
				else               num_end = 1'b1;
			end
			jbt_pkg::M_N_DOT: begin
				if (d) num_nx = jbt_pkg::M_N_FRAC;
				else   num_bad = 1'b1;
			end
			jbt_pkg::M_N_FRAC: begin
				if (d)      num_nx = jbt_pkg::M_N_FRAC;
				else if (e) num_nx = jbt_pkg::M_N_E;
				else        num_end = 1'b1;
			end
			jbt_pkg::M_N_E: begin
				if ((b == "+") || (b == "-")) num_nx = jbt_pkg::M_N_ESIGN;
				else if (d)                   num_nx = jbt_pkg::M_N_EXP;
				else                          num_bad = 1'b1;
			end
			jbt_pkg::M_N_ESIGN: begin
				if (d) num_nx = jbt_pkg::M_N_EXP;
				else   num_bad = 1'b1;
			end
			default: begin
				if (d) num_nx = jbt_pkg::M_N_EXP;
				else   num_end = 1'b1;
			end
		endcase
		num_go = !num_end && !num_bad;
	end

	assign st     = start_tok(b, max_len_q);
	assign lit_ok = (which_e != 2'd3) && (pos_e < jbt_pkg::lit_len(which_e))
		&& (jbt_pkg::lit_char(which_e, pos_e) == b);

	// Main decode: next state and up to two results
	always_comb begin
		mode_d  = mode_e;
		which_d = which_e;
		pos_d   = pos_e;
		cnt_d   = cnt_e;
		r0_v    = 1'b0;
		r1_v    = 1'b0;
		r0      = '0;
		r1      = '0;
		unique case (mode_e)
			jbt_pkg::M_ERROR: begin
				r0_v  = 1'b1;
				r0.ev = jbt_pkg::EV_ERROR;
			end
			jbt_pkg::M_STR, jbt_pkg::M_STR_ESC: begin
				r0_v = 1'b1;
				if (b == 8'h00) begin
					mode_d = jbt_pkg::M_ERROR;
					r0.ev  = jbt_pkg::EV_ERROR;
				end else if ((b == "\"") && (mode_e == jbt_pkg::M_STR)) begin
					r0.ev   = jbt_pkg::EV_TOKEN;
					r0.kind = jbt_pkg::K_STRING;
					mode_d  = jbt_pkg::M_IDLE;
					which_d = 2'd0;
					pos_d   = 3'd0;
					cnt_d   = 16'd0;
				end else if (cnt_e >= max_len_q) begin
					mode_d = jbt_pkg::M_ERROR;
					r0.ev  = jbt_pkg::EV_ERROR;
				end else begin
					mode_d  = (b == "\\") ? jbt_pkg::M_STR_ESC : jbt_pkg::M_STR;
					cnt_d   = cnt_e + 16'd1;
					r0.ev   = jbt_pkg::EV_CONTENT;
					r0.kind = jbt_pkg::K_STRING;
					r0.data = b;
				end
			end
			jbt_pkg::M_N_MINUS, jbt_pkg::M_N_ZERO, jbt_pkg::M_N_INT, jbt_pkg::M_N_DOT,
			jbt_pkg::M_N_FRAC, jbt_pkg::M_N_E, jbt_pkg::M_N_ESIGN, jbt_pkg::M_N_EXP: begin
				r0_v = 1'b1;
				if (num_bad || (num_go && (cnt_e >= max_len_q))) begin
					mode_d = jbt_pkg::M_ERROR;
					r0.ev  = jbt_pkg::EV_ERROR;
				end else if (num_end) begin
					// number closes, byte then starts the next token
					r0.ev   = jbt_pkg::EV_TOKEN;
					r0.kind = jbt_pkg::K_NUMBER;
					mode_d  = st.mode;
					which_d = st.which;
					pos_d   = st.pos;
					cnt_d   = st.cnt;
					r1_v    = st.v;
					r1      = st.res;
				end else begin
					mode_d  = num_nx;
					cnt_d   = cnt_e + 16'd1;
					r0.ev   = jbt_pkg::EV_CONTENT;
					r0.kind = jbt_pkg::K_NUMBER;
					r0.data = b;
				end
			end
			jbt_pkg::M_LIT: begin
				if (!lit_ok) begin
					r0_v   = 1'b1;
					mode_d = jbt_pkg::M_ERROR;
					r0.ev  = jbt_pkg::EV_ERROR;
				end else if ((pos_e + 3'd1) >= jbt_pkg::lit_len(which_e)) begin
					r0_v    = 1'b1;
					r0.ev   = jbt_pkg::EV_TOKEN;
					r0.kind = jbt_pkg::lit_kind(which_e);
					mode_d  = jbt_pkg::M_IDLE;
					which_d = 2'd0;
					pos_d   = 3'd0;
					cnt_d   = 16'd0;
				end else begin
					pos_d = pos_e + 3'd1;
				end
			end
			default: begin
				mode_d  = st.mode;
				which_d = st.which;
				pos_d   = st.pos;
				cnt_d   = st.cnt;
				r0_v    = st.v;
				r0      = st.res;
			end
		endcase
		r0.last = !r1_v;
		r1.last = 1'b1;
	end

	// Lexer state and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= jbt_pkg::M_IDLE;
			which_q   <= 2'd0;
			pos_q     <= 3'd0;
			cnt_q     <= 16'd0;
			max_len_q <= jbt_pkg::MAX_LEN_RESET;
		end else begin
			if (accept) begin
				mode_q  <= mode_d;
				which_q <= which_d;
				pos_q   <= pos_d;
				cnt_q   <= cnt_d;
			end
			if (wr_en)
				max_len_q <= wr_data;
		end
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			fill_q   <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (accept ? {1'b0, r0_v} + {1'b0, r1_v} : 2'd0);
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			fill_q   <= fill_q + (accept ? {2'b0, r0_v} + {2'b0, r1_v} : 3'd0)
				- {2'b0, pop};
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (accept && r0_v)
			fifo_q[wr_ptr_q] <= r0;
		if (accept && r1_v)
			fifo_q[wr_ptr_q + 2'd1] <= r1;
	end

	assign tokens.valid      = (fill_q != 3'd0);
	assign tokens.event_res  = fifo_q[rd_ptr_q].ev;
	assign tokens.token_kind = fifo_q[rd_ptr_q].kind;
	assign tokens.out_byte   = fifo_q[rd_ptr_q].data;
	assign tokens.last       = fifo_q[rd_ptr_q].last;

endmodule

### sv/jbt_checker.sv
// Port-level checks on the tokenizer's result channel, bound into json_byte_tokenizer.
// Depends on jbt_pkg; the bind picks the result channel signals off the tokens port.

module jbt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tok_valid,
	input logic       tok_ready,
	input logic [1:0] event_res,
	input logic [3:0] token_kind,
	input logic [7:0] out_byte,
	input logic       last
);

	// A stalled result stays offered and unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid
			&& $stable({event_res, token_kind, out_byte, last}))
		else $error("result dropped or changed while stalled");

	// Error and end results carry no kind and no byte, and are always last
	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && ((event_res == jbt_pkg::EV_ERROR)
			|| (event_res == jbt_pkg::EV_END))
		|-> (token_kind == 4'd0) && (out_byte == 8'd0) && last)
		else $error("error or end result with payload");

	// Content only ever belongs to a string or a number
	a_content: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (event_res == jbt_pkg::EV_CONTENT)
		|-> (token_kind == jbt_pkg::K_NUMBER)
			|| (token_kind == jbt_pkg::K_STRING))
		else $error("content result with wrong kind");

	// Only a closing number is followed by a second result from the same byte
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !last
		|-> (event_res == jbt_pkg::EV_TOKEN)
			&& (token_kind == jbt_pkg::K_NUMBER) && (out_byte == 8'd0))
		else $error("unexpected first result of a pair");

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (tokens.valid),
	.tok_ready  (tokens.ready),
	.event_res  (tokens.event_res),
	.token_kind (tokens.token_kind),
	.out_byte   (tokens.out_byte),
	.last       (tokens.last)
);

### tb/sv/tb_top.sv
// Self-checking testbench for json_byte_tokenizer: random and directed JSON text
// with burst/gap sending, patterned result stalls and an in-bench lexer predictor.
// Depends on jbt_pkg and the channel interfaces in jbt_if.sv.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import jbt_pkg::*;

	localparam logic [3:0] NO_KIND = 4'd0;
	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic       rst;
		logic [7:0] b;
	} text_item_t;

	typedef enum logic [1:0] {
		NUM_MORE = 2'd0,
		NUM_DONE = 2'd1,
		NUM_BAD  = 2'd2
	} num_step_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [15:0] wr_data;

	jbt_text_if  text_ch ();
	jbt_token_if tok_ch ();

	json_byte_tokenizer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.tokens  (tok_ch),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	// Lexer predictor state
	lex_mode_t   lx_mode;
	logic [1:0]  lx_which;
	logic [2:0]  lx_pos;
	logic [15:0] lx_count;
	logic [15:0] lx_max;
	string       lit_word [3] = '{"true", "false", "null"};
	logic [3:0]  lit_tok [3] = '{K_TRUE, K_FALSE, K_NULL};

	res_t       byte_results [$];
	res_t       tok_expect [$];
	text_item_t text_pending [$];

	int  bytes_queued = 0;
	int  bytes_taken = 0;
	int  miss_count = 0;
	int  hold_asks = 0;
	bit  restart_next = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void note_result(input event_t ev, input logic [3:0] kind,
		input logic [7:0] data);
		res_t r;
		r.ev = ev;
		r.kind = kind;
		r.data = data;
		r.last = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic void lex_clear();
		lx_mode = M_IDLE;
		lx_count = '0;
		lx_which = '0;
		lx_pos = '0;
	endfunction

	function automatic void lex_fail();
		lx_mode = M_ERROR;
		note_result(EV_ERROR, NO_KIND, 8'h00);
	endfunction

	// Content byte, subject to the length limit
	function automatic void take_content(input logic [3:0] kind, input logic [7:0] b);
		if (lx_count >= lx_max) begin
			lex_fail();
		end else begin
			lx_count = lx_count + 16'd1;
			note_result(EV_CONTENT, kind, b);
		end
	endfunction

	function automatic logic dec_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	// Number grammar: next mode, or end of number, or bad byte
	function automatic num_step_t num_advance(input lex_mode_t m, input logic [7:0] b,
		output lex_mode_t nx);
		logic d;
		logic e;
		d = dec_digit(b);
		e = (b == "e") || (b == "E");
		nx = m;
		case (m)
			M_N_MINUS: begin
				if (b == "0") nx = M_N_ZERO;
				else if (d) nx = M_N_INT;
				else return NUM_BAD;
			end
			M_N_ZERO: begin
				if (b == ".") nx = M_N_DOT;
				else if (e) nx = M_N_E;
				else if (d) return NUM_BAD;
				else return NUM_DONE;
			end
			M_N_INT: begin
				if (d) nx = M_N_INT;
				else if (b == ".") nx = M_N_DOT;
				else if (e) nx = M_N_E;
				else return NUM_DONE;
			end
			M_N_DOT: begin
				if (d) nx = M_N_FRAC;
				else return NUM_BAD;
			end
			M_N_FRAC: begin
				if (d) nx = M_N_FRAC;
				else if (e) nx = M_N_E;
				else return NUM_DONE;
			end
			M_N_E: begin
				if (b == "+" || b == "-") nx = M_N_ESIGN;
				else if (d) nx = M_N_EXP;
				else return NUM_BAD;
			end
			M_N_ESIGN: begin
				if (d) nx = M_N_EXP;
				else return NUM_BAD;
			end
			default: begin
				if (d) nx = M_N_EXP;
				else return NUM_DONE;
			end
		endcase
		return NUM_MORE;
	endfunction

	// Byte seen outside any token
	function automatic void token_start(input logic [7:0] b);
		lex_clear();
		case (b)
			8'h00: note_result(EV_END, NO_KIND, 8'h00);
			" ", "\t", "\n", "\r": ;
			"{": note_result(EV_TOKEN, K_LBRACE, 8'h00);
			"}": note_result(EV_TOKEN, K_RBRACE, 8'h00);
			"[": note_result(EV_TOKEN, K_LBRACK, 8'h00);
			"]": note_result(EV_TOKEN, K_RBRACK, 8'h00);
			",": note_result(EV_TOKEN, K_COMMA, 8'h00);
			":": note_result(EV_TOKEN, K_COLON, 8'h00);
			"\"": lx_mode = M_STR;
			"-": begin
				lx_mode = M_N_MINUS;
				take_content(K_NUMBER, b);
			end
			"0": begin
				lx_mode = M_N_ZERO;
				take_content(K_NUMBER, b);
			end
			"t", "f", "n": begin
				lx_mode = M_LIT;
				lx_which = (b == "t") ? LIT_TRUE : (b == "f") ? LIT_FALSE : LIT_NULL;
				lx_pos = 3'd1;
			end
			default: begin
				if (dec_digit(b)) begin
					lx_mode = M_N_INT;
					take_content(K_NUMBER, b);
				end else begin
					lex_fail();
				end
			end
		endcase
	endfunction

	// One accepted text byte: update state and queue its results
	function automatic void lex_byte(input logic [7:0] b, input logic rst);
		lex_mode_t nx;
		num_step_t adv;
		res_t      r;
		byte_results.delete();
		if (rst) lex_clear();
		if (lx_mode == M_ERROR) begin
			note_result(EV_ERROR, NO_KIND, 8'h00);
		end else if (lx_mode == M_STR || lx_mode == M_STR_ESC) begin
			if (b == 8'h00) begin
				lex_fail();
			end else if (b == "\"" && lx_mode == M_STR) begin
				note_result(EV_TOKEN, K_STRING, 8'h00);
				lex_clear();
			end else begin
				lx_mode = (b == "\\") ? M_STR_ESC : M_STR;
				take_content(K_STRING, b);
			end
		end else if (lx_mode >= M_N_MINUS && lx_mode <= M_N_EXP) begin
			adv = num_advance(lx_mode, b, nx);
			case (adv)
				NUM_BAD: lex_fail();
				NUM_DONE: begin
					note_result(EV_TOKEN, K_NUMBER, 8'h00);
					token_start(b);
				end
				default: begin
					lx_mode = nx;
					take_content(K_NUMBER, b);
				end
			endcase
		end else if (lx_mode == M_LIT) begin
			if (b != lit_word[lx_which][lx_pos]) begin
				lex_fail();
			end else if (int'(lx_pos) + 1 == lit_word[lx_which].len()) begin
				note_result(EV_TOKEN, lit_tok[lx_which], 8'h00);
				lex_clear();
			end else begin
				lx_pos = lx_pos + 3'd1;
			end
		end else begin
			token_start(b);
		end
		foreach (byte_results[i]) begin
			r = byte_results[i];
			r.last = (i == byte_results.size() - 1);
			tok_expect.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------- text sender

	int         burst_left;
	int         gap_left;
	text_item_t next_item;

	task automatic pick_burst();
		if ($urandom_range(0, 5) == 0) begin
			burst_left = $urandom_range(40, 120);
			gap_left = 0;
		end else begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		end
	endtask

	// Offer queued bytes; predict each one as its transaction completes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
			text_ch.in_byte <= 8'h00;
			text_ch.restart <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				lex_byte(text_ch.in_byte, text_ch.restart);
				bytes_taken++;
			end
			if (!text_ch.valid || text_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					text_ch.valid <= 1'b0;
				end else if (text_pending.size() != 0) begin
					next_item = text_pending.pop_front();
					text_ch.valid <= 1'b1;
					text_ch.in_byte <= next_item.b;
					text_ch.restart <= next_item.rst;
					if (burst_left > 1) burst_left--;
					else pick_burst();
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- result receiver

	int hold_seen;
	int hold_left;
	int rx_style;
	int style_left;
	int rx_phase;

	// Ready pattern of its own, with an occasional long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
			rx_style = 0;
			style_left = 0;
			rx_phase = 0;
		end else begin
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (style_left == 0) begin
				rx_style = $urandom_range(0, 3);
				style_left = $urandom_range(16, 160);
			end else begin
				style_left--;
			end
			rx_phase++;
			if (hold_left != 0) begin
				hold_left--;
				tok_ch.ready <= 1'b0;
			end else begin
				case (rx_style)
					0: tok_ch.ready <= 1'b1;
					1: tok_ch.ready <= ($urandom_range(0, 9) < 7);
					2: tok_ch.ready <= ((rx_phase % 5) >= 2);
					default: tok_ch.ready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- result checker

	res_t seen;
	res_t want;

	always @(posedge clk) begin
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			seen.ev = event_t'(tok_ch.event_res);
			seen.kind = tok_ch.token_kind;
			seen.data = tok_ch.out_byte;
			seen.last = tok_ch.last;
			if (tok_expect.size() == 0) begin
				miss_count++;
				if (miss_count <= 10)
					$display("unexpected result: ev=%0d kind=%0d byte=%02h last=%0d",
						seen.ev, seen.kind, seen.data, seen.last);
			end else begin
				want = tok_expect.pop_front();
				if (seen.ev !== want.ev || seen.kind !== want.kind ||
					seen.data !== want.data || seen.last !== want.last) begin
					miss_count++;
					if (miss_count <= 10)
						$display("mismatch: expected ev=%0d kind=%0d byte=%02h last=%0d, %s",
							want.ev, want.kind, want.data, want.last,
							$sformatf("got ev=%0d kind=%0d byte=%02h last=%0d",
								seen.ev, seen.kind, seen.data, seen.last));
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	int stuck = 0;

	// Cycles with work outstanding but no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready) ||
			(text_pending.size() == 0 && !text_ch.valid && tok_expect.size() == 0)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- text generation

	task automatic push_byte(input logic [7:0] b, input logic rst);
		text_item_t it;
		it.b = b;
		it.rst = rst | restart_next;
		restart_next = 1'b0;
		text_pending.push_back(it);
		bytes_queued++;
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
	endtask

	task automatic put_blanks();
		string blanks;
		blanks = " \t\n\r";
		repeat ($urandom_range(0, 2)) push_byte(blanks[$urandom_range(0, 3)], 1'b0);
	endtask

	// String with random content, some escaped quotes
	task automatic put_string();
		int         n;
		logic [7:0] c;
		push_byte("\"", 1'b0);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0) begin
				push_byte("\\", 1'b0);
				push_byte(($urandom_range(0, 1) != 0) ? "\"" : "n", 1'b0);
			end else begin
				c = 8'($urandom_range(1, 255));
				if (c == "\"" || c == "\\") c = "q";
				push_byte(c, 1'b0);
			end
		end
		push_byte("\"", 1'b0);
	endtask

	// Well-formed number: sign, integer part, fraction, exponent
	task automatic put_number();
		if ($urandom_range(0, 2) == 0) push_byte("-", 1'b0);
		if ($urandom_range(0, 3) == 0) begin
			push_byte("0", 1'b0);
		end else begin
			push_byte("0" + 8'($urandom_range(1, 9)), 1'b0);
			repeat ($urandom_range(0, 3)) push_byte("0" + 8'($urandom_range(0, 9)), 1'b0);
		end
		if ($urandom_range(0, 2) == 0) begin
			push_byte(".", 1'b0);
			repeat ($urandom_range(1, 3)) push_byte("0" + 8'($urandom_range(0, 9)), 1'b0);
		end
		if ($urandom_range(0, 2) == 0) begin
			push_byte(($urandom_range(0, 1) != 0) ? "e" : "E", 1'b0);
			case ($urandom_range(0, 2))
				0: push_byte("+", 1'b0);
				1: push_byte("-", 1'b0);
				default: ;
			endcase
			repeat ($urandom_range(1, 3)) push_byte("0" + 8'($urandom_range(0, 9)), 1'b0);
		end
	endtask

	// Literal, now and then misspelt
	task automatic put_literal();
		string s;
		s = lit_word[$urandom_range(0, 2)];
		if ($urandom_range(0, 11) == 0) s[$urandom_range(0, s.len() - 1)] = "x";
		put_str(s);
	endtask

	// One text: tokens with blanks, light noise, usually closed by a zero byte
	task automatic gen_text(input int n_tok);
		string puncts;
		puncts = "{}[],:";
		if ($urandom_range(0, 1) != 0) restart_next = 1'b1;
		repeat (n_tok) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3: push_byte(puncts[$urandom_range(0, 5)], 1'b0);
				4, 5: put_string();
				6, 7: put_number();
				8, 9: put_literal();
				default: ;
			endcase
			put_blanks();
			if ($urandom_range(0, 19) == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
			if ($urandom_range(0, 39) == 0) restart_next = 1'b1;
		end
		if ($urandom_range(0, 19) < 17) push_byte(8'h00, 1'b0);
	endtask

	task automatic random_texts(input int n_items);
		int goal;
		goal = bytes_queued + n_items;
		while (bytes_queued < goal) gen_text($urandom_range(1, 12));
	endtask

	// Sender pause: everything sent, every result back, block settled
	task automatic drain();
		while (bytes_taken != bytes_queued || tok_expect.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [15:0] v);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		lx_max = v;
	endtask

	// ---------------------------------------------------------------- test sequence

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_data = 16'h0000;
		text_ch.valid = 1'b0;
		text_ch.in_byte = 8'h00;
		text_ch.restart = 1'b0;
		tok_ch.ready = 1'b0;
		lx_max = MAX_LEN_RESET;
		lex_clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: escapes, control and top bytes in a string, full number
		// grammar closed by punctuation, literal mismatch, error hold, digit
		// after leading zero, unterminated string, end of text
		push_byte("{", 1'b1);
		put_str("\"\\\"");
		push_byte(8'h01, 1'b0);
		push_byte(8'hFF, 1'b0);
		put_str("\":\t-0.5E+9]nx");
		push_byte(8'h00, 1'b0);
		push_byte("0", 1'b1);
		push_byte("7", 1'b0);
		push_byte("\"", 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b1);
		drain();

		// Reset length limit; long receiver hold-off part way in
		random_texts(300);
		hold_asks++;
		drain();
		random_texts(100);
		drain();

		// Limit of one: strings and numbers overflow at their second content byte
		set_max_len(16'd1);
		push_byte("\"", 1'b1);
		put_str("ab\"");
		push_byte("1", 1'b1);
		push_byte("2", 1'b0);
		push_byte(8'h00, 1'b1);
		random_texts(150);
		drain();

		// Longest limit, with a second hold-off
		set_max_len(16'hFFFF);
		random_texts(350);
		hold_asks++;
		drain();

		set_max_len(16'd4);
		random_texts(150);
		drain();

		repeat (8) @(posedge clk);
		if (tok_expect.size() != 0) begin
			miss_count += tok_expect.size();
			$display("%0d expected results never arrived", tok_expect.size());
		end
		if (miss_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
